// ===== hdl/dmwc_pkg.sv =====
package dmwc_pkg;

   // Field widths of the pixel and result items.
   localparam int PIX_W  = 8;
   localparam int ROW_W  = 12;
   localparam int COL_W  = 10;

   // Configuration register widths and indexes.
   localparam int FW_W       = 11;
   localparam int FH_W       = 12;
   localparam int MASK_W     = 63;
   localparam int CSR_ADDR_W = 2;

   localparam logic [CSR_ADDR_W-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_FRAME_HEIGHT = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_MASK_A       = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_MASK_B       = 2'd3;

   localparam logic [FW_W-1:0]   FRAME_WIDTH_RST  = 11'd640;
   localparam logic [FH_W-1:0]   FRAME_HEIGHT_RST = 12'd480;
   localparam logic [MASK_W-1:0] MASK_RST         = 63'd72624976668147841;

   localparam logic [FH_W-1:0] HEIGHT_MIN = 12'd3;

   // Convolution arithmetic: 3x3 window, 7-bit signed coefficients.
   localparam int TAPS     = 9;
   localparam int ROWS     = 3;
   localparam int COEF_W   = 7;
   localparam int PROD_W   = 16;
   localparam int ROWSUM_W = 18;
   localparam int SUM_W    = 19;
   localparam int MAG_W    = 19;
   localparam logic [PIX_W-1:0] PIX_MAX = 8'hFF;

   // Result queue sizing.
   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_PTR_W = 3;
   localparam int FIFO_CNT_W = 4;

   typedef logic [TAPS-1:0][PIX_W-1:0] window_type;

   // Position and flags of an item travelling down the pipeline.
   typedef struct packed {
      logic             emit;
      logic             last;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
   } info_type;

   typedef struct packed {
      logic             last;
      logic [PIX_W-1:0] value;
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
   } result_type;

endpackage

// ===== hdl/dmwc_window.sv =====
module dmwc_window
   import dmwc_pkg::*;
#(
   parameter int MAX_WIDTH = 1024,
   parameter int ADDR_W    = 10
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [ADDR_W-1:0] in_addr,
   input  logic [PIX_W-1:0]  in_pixel,
   input  info_type          in_info,
   output logic              out_valid,
   output window_type        out_window,
   output info_type          out_info
);

   localparam int WORD_W = 2 * PIX_W;

   // Both line stores share one word per column: upper row high, middle row low.
   logic [WORD_W-1:0] line_mem [MAX_WIDTH];
   logic [WORD_W-1:0] rd_ff;

   logic              p1_valid_ff;
   logic [ADDR_W-1:0] p1_addr_ff;
   logic [PIX_W-1:0]  p1_pixel_ff;
   info_type          p1_info_ff;

   logic              fw_valid_ff;
   logic [ADDR_W-1:0] fw_addr_ff;
   logic [WORD_W-1:0] fw_data_ff;

   logic [WORD_W-1:0] line_word;
   logic [PIX_W-1:0]  top_pix;
   logic [PIX_W-1:0]  mid_pix;
   logic [WORD_W-1:0] wr_data;

   window_type        window_ff;
   window_type        window_in;
   logic              out_valid_ff;
   info_type          out_info_ff;

   // The read issued in the same cycle as the previous write to that column
   // returned the old word, so the written word is forwarded instead.
   always_comb begin
      if (fw_valid_ff && (fw_addr_ff == p1_addr_ff)) begin
         line_word = fw_data_ff;
      end else begin
         line_word = rd_ff;
      end
      top_pix = line_word[WORD_W-1:PIX_W];
      mid_pix = line_word[PIX_W-1:0];
      wr_data = {mid_pix, p1_pixel_ff};
   end

   // Line store memory: read on transfer, written back in the next cycle.
   always_ff @(posedge clock) begin
      if (p1_valid_ff) begin
         line_mem[p1_addr_ff] <= wr_data;
      end
      if (in_valid) begin
         rd_ff <= line_mem[in_addr];
      end
   end

   // Read stage and forwarding record.
   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         fw_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff <= in_valid;
         fw_valid_ff <= p1_valid_ff;
      end
      p1_addr_ff  <= in_addr;
      p1_pixel_ff <= in_pixel;
      p1_info_ff  <= in_info;
      fw_addr_ff  <= p1_addr_ff;
      fw_data_ff  <= wr_data;
   end

   // Shift the window one column left and bring in the new column.
   always_comb begin
      window_in = window_ff;
      for (int k = 0; k < ROWS; k++) begin
         window_in[3*k]     = window_ff[3*k+1];
         window_in[3*k + 1] = window_ff[3*k+2];
      end
      window_in[2] = top_pix;
      window_in[5] = mid_pix;
      window_in[8] = p1_pixel_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (p1_valid_ff) begin
            window_ff <= window_in;
         end
         out_valid_ff <= p1_valid_ff && p1_info_ff.emit;
      end
      out_info_ff <= p1_info_ff;
   end

   assign out_valid  = out_valid_ff;
   assign out_window = window_ff;
   assign out_info   = out_info_ff;

endmodule

// ===== hdl/dmwc_conv.sv =====
module dmwc_conv
   import dmwc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  window_type        in_window,
   input  info_type          in_info,
   input  logic [MASK_W-1:0] mask_a,
   input  logic [MASK_W-1:0] mask_b,
   output logic              out_valid,
   output result_type        out_result
);

   // Unsigned pixel times signed coefficient; the product always fits 16 bits.
   function automatic logic signed [PROD_W-1:0] tap_product(
      input logic [PIX_W-1:0]  pix,
      input logic [COEF_W-1:0] coef
   );
      logic signed [PROD_W-1:0] pix_ext;
      logic signed [PROD_W-1:0] coef_ext;
      pix_ext  = {{(PROD_W-PIX_W){1'b0}}, pix};
      coef_ext = {{(PROD_W-COEF_W){coef[COEF_W-1]}}, coef};
      return pix_ext * coef_ext;
   endfunction

   logic signed [PROD_W-1:0]   prod_a_in  [TAPS];
   logic signed [PROD_W-1:0]   prod_b_in  [TAPS];
   logic signed [PROD_W-1:0]   prod_a_ff  [TAPS];
   logic signed [PROD_W-1:0]   prod_b_ff  [TAPS];
   logic signed [ROWSUM_W-1:0] rsum_a_in  [ROWS];
   logic signed [ROWSUM_W-1:0] rsum_b_in  [ROWS];
   logic signed [ROWSUM_W-1:0] rsum_a_ff  [ROWS];
   logic signed [ROWSUM_W-1:0] rsum_b_ff  [ROWS];
   logic signed [SUM_W-1:0]    total_a;
   logic signed [SUM_W-1:0]    total_b;
   logic [SUM_W-1:0]           abs_a;
   logic [SUM_W-1:0]           abs_b;
   logic [MAG_W-1:0]           mag;
   result_type                 result_in;

   logic       v1_ff;
   logic       v2_ff;
   logic       out_valid_ff;
   info_type   info1_ff;
   info_type   info2_ff;
   result_type result_ff;

   // Stage 1: eighteen tap products.
   always_comb begin
      for (int t = 0; t < TAPS; t++) begin
         prod_a_in[t] = tap_product(in_window[t], mask_a[COEF_W*t +: COEF_W]);
         prod_b_in[t] = tap_product(in_window[t], mask_b[COEF_W*t +: COEF_W]);
      end
   end

   // Stage 2: one sum per window row.
   always_comb begin
      for (int k = 0; k < ROWS; k++) begin
         rsum_a_in[k] = ROWSUM_W'(prod_a_ff[3*k]) + ROWSUM_W'(prod_a_ff[3*k+1])
                      + ROWSUM_W'(prod_a_ff[3*k+2]);
         rsum_b_in[k] = ROWSUM_W'(prod_b_ff[3*k]) + ROWSUM_W'(prod_b_ff[3*k+1])
                      + ROWSUM_W'(prod_b_ff[3*k+2]);
      end
   end

   // Stage 3: mask totals, absolute values, their sum and the clip to 8 bits.
   always_comb begin
      total_a = SUM_W'(rsum_a_ff[0]) + SUM_W'(rsum_a_ff[1]) + SUM_W'(rsum_a_ff[2]);
      total_b = SUM_W'(rsum_b_ff[0]) + SUM_W'(rsum_b_ff[1]) + SUM_W'(rsum_b_ff[2]);
      abs_a   = total_a[SUM_W-1] ? (~total_a + 1'b1) : total_a;
      abs_b   = total_b[SUM_W-1] ? (~total_b + 1'b1) : total_b;
      mag     = MAG_W'(abs_a) + MAG_W'(abs_b);
      result_in.row  = info2_ff.row;
      result_in.col  = info2_ff.col;
      result_in.last = info2_ff.last;
      if (mag > MAG_W'(PIX_MAX)) begin
         result_in.value = PIX_MAX;
      end else begin
         result_in.value = mag[PIX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         v1_ff        <= in_valid;
         v2_ff        <= v1_ff;
         out_valid_ff <= v2_ff;
      end
      prod_a_ff <= prod_a_in;
      prod_b_ff <= prod_b_in;
      rsum_a_ff <= rsum_a_in;
      rsum_b_ff <= rsum_b_in;
      info1_ff  <= in_info;
      info2_ff  <= info1_ff;
      result_ff <= result_in;
   end

   assign out_valid  = out_valid_ff;
   assign out_result = result_ff;

endmodule

// ===== hdl/dmwc_result_fifo.sv =====
module dmwc_result_fifo
   import dmwc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  result_type push_data,
   input  logic       pop,
   output logic       out_valid,
   output result_type out_data
);

   result_type            slot_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff;
   logic [FIFO_PTR_W-1:0] rd_ptr_ff;
   logic [FIFO_CNT_W-1:0] count_ff;
   logic [FIFO_CNT_W-1:0] count_in;

   // Occupancy follows pushes and pops; the caller keeps it within depth.
   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign out_valid = (count_ff != '0);
   assign out_data  = slot_ff[rd_ptr_ff];

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push && !pop |-> count_ff != FIFO_CNT_W'(FIFO_DEPTH))
      else $error("result queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("result queue read while empty");
`endif

endmodule

// ===== hdl/dual_mask_window_convolution.sv =====
// Two-mask 3x3 convolution with L1 magnitude. Pixels enter in raster order on
// the req_ channel, one per clock at full rate; each pixel takes one read and
// one write of the single line-store memory at its column, which is what sets
// the rate of one pixel per cycle. For each interior pixel the block offers
// min(255, |A*w| + |B*w|) with its row and column on the rsp_ channel once
// its completing pixel has passed the window and convolution registers;
// border pixels produce no result. An eight-entry result queue absorbs stalls
// on the output, and req_tready drops only when eight results are owed. Frame
// size and masks may be written only while no pixel is in flight and no
// result is owed. The line store needs no clearing after reset.
module dual_mask_window_convolution
   import dmwc_pkg::*;
#(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   // Pixel input.
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // pixel[7:0]
   input  logic                  req_tuser,   // frame_start
   // Results.
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [31:0]           rsp_tdata,   // out_row[11:0], out_col[21:12], value[29:22]
   output logic                  rsp_tlast,
   // Configuration writes.
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [MASK_W-1:0]     csr_wdata
);

   localparam int ADDR_W = $clog2(MAX_WIDTH);
   localparam int WCMP_W = ($clog2(MAX_WIDTH + 1) > FW_W) ? $clog2(MAX_WIDTH + 1) : FW_W;
   localparam logic [WCMP_W-1:0] WIDTH_MAX = WCMP_W'(MAX_WIDTH);
   localparam logic [WCMP_W-1:0] WIDTH_MIN = WCMP_W'(3);
   localparam logic [WCMP_W-1:0] EDGE_MIN  = WCMP_W'(2);
   localparam logic [ROW_W-1:0]  ROW_EDGE  = ROW_W'(2);

   logic [FW_W-1:0]   frame_width_ff;
   logic [FH_W-1:0]   frame_height_ff;
   logic [MASK_W-1:0] mask_a_ff;
   logic [MASK_W-1:0] mask_b_ff;

   logic [ADDR_W-1:0] col_ff;
   logic [ADDR_W-1:0] col_in;
   logic [ROW_W-1:0]  row_ff;
   logic [ROW_W-1:0]  row_in;

   logic              req_xfer;
   logic              rsp_xfer;
   logic [WCMP_W-1:0] used_w;
   logic [FH_W-1:0]   used_h;
   logic [ADDR_W-1:0] c_cur;
   logic [ROW_W-1:0]  r_cur;
   logic [WCMP_W-1:0] c_ext;
   logic [WCMP_W-1:0] c_inc;
   logic [ROW_W:0]    r_inc;
   logic [WCMP_W-1:0] c_less;
   info_type          s0_info;

   logic              win_valid;
   window_type        win_taps;
   info_type          win_info;
   logic              conv_valid;
   result_type        conv_result;
   result_type        rsp_result;

   logic [FIFO_CNT_W-1:0] occ_ff;
   logic [FIFO_CNT_W-1:0] occ_in;

   assign req_xfer = req_tvalid && req_tready;
   assign rsp_xfer = rsp_tvalid && rsp_tready;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RST;
         frame_height_ff <= FRAME_HEIGHT_RST;
         mask_a_ff       <= MASK_RST;
         mask_b_ff       <= MASK_RST;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_FRAME_WIDTH:  frame_width_ff  <= csr_wdata[FW_W-1:0];
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_wdata[FH_W-1:0];
            CSR_MASK_A:       mask_a_ff       <= csr_wdata;
            CSR_MASK_B:       mask_b_ff       <= csr_wdata;
         endcase
      end
   end

   // Frame size in use, clamped to the supported range.
   always_comb begin
      used_w = WCMP_W'(frame_width_ff);
      if (used_w < WIDTH_MIN) begin
         used_w = WIDTH_MIN;
      end else if (used_w > WIDTH_MAX) begin
         used_w = WIDTH_MAX;
      end
      used_h = (frame_height_ff < HEIGHT_MIN) ? HEIGHT_MIN : frame_height_ff;
   end

   // Position of the incoming pixel, what it emits and where the counters go next.
   always_comb begin
      c_cur  = req_tuser ? '0 : col_ff;
      r_cur  = req_tuser ? '0 : row_ff;
      c_ext  = WCMP_W'(c_cur);
      c_inc  = c_ext + 1'b1;
      r_inc  = {1'b0, r_cur} + 1'b1;
      c_less = c_ext - 1'b1;

      s0_info.emit = (r_cur >= ROW_EDGE) && (c_ext >= EDGE_MIN);
      s0_info.row  = r_cur - 1'b1;
      s0_info.col  = c_less[COL_W-1:0];
      s0_info.last = (r_cur == (used_h - 1'b1)) && (c_ext == (used_w - 1'b1));

      if (c_inc >= used_w) begin
         col_in = '0;
         row_in = (r_inc >= {1'b0, used_h}) ? '0 : r_inc[ROW_W-1:0];
      end else begin
         col_in = c_inc[ADDR_W-1:0];
         row_in = r_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (req_xfer) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Results owed: counted at the input transfer, released at the output transfer.
   always_comb begin
      occ_in = occ_ff;
      if (req_xfer && s0_info.emit && !rsp_xfer) begin
         occ_in = occ_ff + 1'b1;
      end else if (rsp_xfer && !(req_xfer && s0_info.emit)) begin
         occ_in = occ_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   assign req_tready = (occ_ff < FIFO_CNT_W'(FIFO_DEPTH));

   dmwc_window #(
      .MAX_WIDTH (MAX_WIDTH),
      .ADDR_W    (ADDR_W)
   ) u_window (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_xfer),
      .in_addr    (c_cur),
      .in_pixel   (req_tdata),
      .in_info    (s0_info),
      .out_valid  (win_valid),
      .out_window (win_taps),
      .out_info   (win_info)
   );

   dmwc_conv u_conv (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (win_valid),
      .in_window  (win_taps),
      .in_info    (win_info),
      .mask_a     (mask_a_ff),
      .mask_b     (mask_b_ff),
      .out_valid  (conv_valid),
      .out_result (conv_result)
   );

   dmwc_result_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (conv_valid),
      .push_data (conv_result),
      .pop       (rsp_xfer),
      .out_valid (rsp_tvalid),
      .out_data  (rsp_result)
   );

   assign rsp_tdata = {2'b00, rsp_result.value, rsp_result.col, rsp_result.row};
   assign rsp_tlast = rsp_result.last;

`ifndef SYNTHESIS
   a_owed_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= FIFO_CNT_W'(FIFO_DEPTH))
      else $error("more results owed than the queue holds");

   a_col_bound: assert property (@(posedge clock) disable iff (reset)
      WCMP_W'(col_ff) < WIDTH_MAX)
      else $error("column counter beyond the line store");

   a_rsp_owed: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> occ_ff != '0)
      else $error("result offered that was never owed");

   a_frame_restart: assert property (@(posedge clock) disable iff (reset)
      req_xfer && req_tuser |=> (col_ff == ADDR_W'(1)) && (row_ff == '0))
      else $error("frame start did not restart the position counters");
`endif

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
   import dmwc_pkg::*;

   localparam int LINE_MAX     = 1024;
   localparam int DRAIN_CYCLES = 16;
   localparam int RANDOM_ITEMS = 250;
   localparam int HOLD_AFTER   = 30;

   // Every coefficient at its most negative, and every one at its most positive.
   localparam logic [MASK_W-1:0] MASK_ALL_NEG = {9{7'h40}};
   localparam logic [MASK_W-1:0] MASK_ALL_POS = {9{7'h3F}};

   typedef struct packed {
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic [PIX_W-1:0] value;
      logic             last;
   } mag_pixel_type;

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic             sof;
      logic             fixed;
      mag_pixel_type    want;
   } stim_row_type;

   localparam mag_pixel_type NONE        = '0;
   localparam mag_pixel_type CENTRE_FULL = '{12'd1, 10'd1, 8'hFF, 1'b1};
   localparam mag_pixel_type CENTRE_DARK = '{12'd1, 10'd1, 8'h00, 1'b1};

   // Directed stimulus on a 3x3 frame with the reset masks (all coefficients one).
   localparam stim_row_type DIRECTED_ROWS [25] = '{
      // Bright frame: the sum of nine full-scale pixels saturates.
      '{8'hFF, 1'b1, 1'b0, NONE},
      '{8'hFF, 1'b0, 1'b0, NONE},
      '{8'hFF, 1'b0, 1'b0, NONE},
      '{8'hFF, 1'b0, 1'b0, NONE},
      '{8'hFF, 1'b0, 1'b0, NONE},
      '{8'hFF, 1'b0, 1'b0, NONE},
      '{8'hFF, 1'b0, 1'b0, NONE},
      '{8'hFF, 1'b0, 1'b0, NONE},
      '{8'hFF, 1'b0, 1'b1, CENTRE_FULL},
      // Dark frame, entered by the row counter wrapping without a frame start.
      '{8'h00, 1'b0, 1'b0, NONE},
      '{8'h00, 1'b0, 1'b0, NONE},
      '{8'h00, 1'b0, 1'b0, NONE},
      '{8'h00, 1'b0, 1'b0, NONE},
      '{8'h00, 1'b0, 1'b0, NONE},
      '{8'h00, 1'b0, 1'b0, NONE},
      '{8'h00, 1'b0, 1'b0, NONE},
      '{8'h00, 1'b0, 1'b0, NONE},
      '{8'h00, 1'b0, 1'b1, CENTRE_DARK},
      // A frame cut short by a frame start at the beginning of its second row.
      '{8'h55, 1'b0, 1'b0, NONE},
      '{8'hAA, 1'b0, 1'b0, NONE},
      '{8'h01, 1'b0, 1'b0, NONE},
      '{8'h80, 1'b1, 1'b0, NONE},
      '{8'h7F, 1'b0, 1'b0, NONE},
      '{8'h00, 1'b0, 1'b0, NONE},
      '{8'hFF, 1'b0, 1'b0, NONE}
   };

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [7:0]            req_tdata;   // pixel[7:0]
   logic                  req_tuser;   // frame_start
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [31:0]           rsp_tdata;   // out_row[11:0], out_col[21:12], value[29:22]
   logic                  rsp_tlast;   // last_of_frame
   logic                  csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [MASK_W-1:0]     csr_wdata;

   // Predictor state: line stores, window, raster position and register copies.
   bit [PIX_W-1:0]  rows_upper  [LINE_MAX];
   bit [PIX_W-1:0]  rows_middle [LINE_MAX];
   bit [PIX_W-1:0]  window3x3   [TAPS];
   bit [COL_W-1:0]  col_pos;
   bit [ROW_W-1:0]  row_pos;
   logic [FW_W-1:0]   cfg_width  = FRAME_WIDTH_RST;
   logic [FH_W-1:0]   cfg_height = FRAME_HEIGHT_RST;
   logic [MASK_W-1:0] cfg_mask_a = MASK_RST;
   logic [MASK_W-1:0] cfg_mask_b = MASK_RST;

   mag_pixel_type owed[$];
   int errors       = 0;
   int results_seen = 0;
   int items_sent   = 0;
   int burst_left   = 0;

   dual_mask_window_convolution u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic int coefficient(input logic [MASK_W-1:0] mask, input int tap);
      logic signed [COEF_W-1:0] raw;
      raw = mask[COEF_W*tap +: COEF_W];
      return int'(raw);
   endfunction

   function automatic int active_width();
      int w;
      w = int'(cfg_width);
      if (w < 3) w = 3;
      if (w > LINE_MAX) w = LINE_MAX;
      return w;
   endfunction

   function automatic int active_height();
      int h;
      h = int'(cfg_height);
      if (h < 3) h = 3;
      return h;
   endfunction

   // Takes one pixel into the window and returns 1 when an interior pixel is due.
   function automatic bit convolve_pixel(input logic [PIX_W-1:0] px, input logic sof,
                                         output mag_pixel_type res);
      int w, h, r, c, k, acc_a, acc_b, mag;
      bit [PIX_W-1:0] top, mid;
      bit emits;
      w = active_width();
      h = active_height();
      res = '0;
      emits = 1'b0;
      if (sof) begin
         col_pos = '0;
         row_pos = '0;
      end
      r = int'(row_pos);
      c = int'(col_pos);
      top = rows_upper[col_pos];
      mid = rows_middle[col_pos];
      rows_upper[col_pos]  = mid;
      rows_middle[col_pos] = px;
      for (k = 0; k < 3; k++) begin
         window3x3[3*k]   = window3x3[3*k+1];
         window3x3[3*k+1] = window3x3[3*k+2];
      end
      window3x3[2] = top;
      window3x3[5] = mid;
      window3x3[8] = px;
      if (r >= 2 && c >= 2) begin
         acc_a = 0;
         acc_b = 0;
         for (k = 0; k < TAPS; k++) begin
            acc_a += int'(window3x3[k]) * coefficient(cfg_mask_a, k);
            acc_b += int'(window3x3[k]) * coefficient(cfg_mask_b, k);
         end
         mag = (acc_a < 0 ? -acc_a : acc_a) + (acc_b < 0 ? -acc_b : acc_b);
         if (mag > 255) mag = 255;
         res.row   = ROW_W'(r - 1);
         res.col   = COL_W'(c - 1);
         res.value = PIX_W'(mag);
         res.last  = (r == h - 1) && (c == w - 1);
         emits = 1'b1;
      end
      c++;
      if (c >= w) begin
         c = 0;
         r++;
         if (r >= h) r = 0;
      end
      col_pos = COL_W'(c);
      row_pos = ROW_W'(r);
      return emits;
   endfunction

   function automatic logic [MASK_W-1:0] random_mask();
      logic [MASK_W-1:0] m;
      int t;
      case ($urandom_range(0, 7))
         0: m = MASK_ALL_NEG;
         1: m = MASK_ALL_POS;
         2: m = '0;
         3: m = MASK_RST;
         4, 5: m = MASK_W'({$urandom, $urandom});
         default: begin
            // Small coefficients, from -3 to 3 at each tap.
            for (t = 0; t < TAPS; t++) m[COEF_W*t +: COEF_W] = COEF_W'($urandom_range(0, 6) - 3);
         end
      endcase
      return m;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      errors++;
      if (errors <= 50) begin
         $display("tb: %s mismatch at %0t: got %0d, expected %0d", what, $time, got, want);
      end
   endtask

   task automatic write_register(input logic [CSR_ADDR_W-1:0] addr,
                                 input logic [MASK_W-1:0] data);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic configure(input logic [FW_W-1:0] w, input logic [FH_W-1:0] h,
                            input logic [MASK_W-1:0] ma, input logic [MASK_W-1:0] mb);
      write_register(CSR_FRAME_WIDTH, MASK_W'(w));
      write_register(CSR_FRAME_HEIGHT, MASK_W'(h));
      write_register(CSR_MASK_A, ma);
      write_register(CSR_MASK_B, mb);
      csr_we     <= 1'b0;
      cfg_width  = w;
      cfg_height = h;
      cfg_mask_a = ma;
      cfg_mask_b = mb;
   endtask

   // Offers one pixel in bursts with random gaps and predicts its outcome on transfer.
   task automatic offer_pixel(input logic [PIX_W-1:0] px, input logic sof,
                              input logic fixed, input mag_pixel_type want);
      int gap;
      bit emits;
      mag_pixel_type got;
      if (burst_left == 0) begin
         if ($urandom_range(0, 3) == 0) begin
            burst_left = $urandom_range(50, 200);
            gap = 0;
         end else begin
            burst_left = $urandom_range(1, 24);
            gap = $urandom_range(0, 6);
         end
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= px;
      req_tuser  <= sof;
      // Handshake signals are settled by the falling edge; the transfer follows.
      @(negedge clock);
      while (!req_tready) @(negedge clock);
      @(posedge clock);
      items_sent++;
      emits = convolve_pixel(px, sof, got);
      if (fixed) owed.push_back(want);
      else if (emits) owed.push_back(got);
   endtask

   // Random pixels; frames mostly open with a frame start, in noisy runs rarely broken by a stray one.
   task automatic run_phase(input int count, input int span, input bit noisy);
      int i, pick;
      logic sof;
      logic [PIX_W-1:0] px;
      for (i = 0; i < count; i++) begin
         pick = $urandom_range(0, 7);
         if (pick == 0) px = '0;
         else if (pick == 1) px = PIX_W'(span);
         else px = PIX_W'($urandom_range(0, span));
         if (i == 0) sof = 1'b1;
         else if (col_pos == 0 && row_pos == 0) sof = ($urandom_range(0, 3) != 0);
         else sof = noisy && ($urandom_range(0, 99) == 0);
         offer_pixel(px, sof, 1'b0, NONE);
      end
      req_tvalid <= 1'b0;
   endtask

   // Waits for every owed result, then lets in-flight border pixels clear.
   task automatic wait_idle();
      while (owed.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Main sequence.
   initial begin
      int i, n, random_items, span, sel;
      logic [FW_W-1:0] w;
      logic [FH_W-1:0] h;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= 1'b0;
      csr_we     <= 1'b0;
      csr_addr   <= CSR_FRAME_WIDTH;
      csr_wdata  <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      configure(11'd3, 12'd3, MASK_RST, MASK_RST);
      for (i = 0; i < 25; i++) begin
         offer_pixel(DIRECTED_ROWS[i].pixel, DIRECTED_ROWS[i].sof,
                     DIRECTED_ROWS[i].fixed, DIRECTED_ROWS[i].want);
      end
      req_tvalid <= 1'b0;
      wait_idle();

      // Width and height below the minimum, with opposite extreme masks.
      configure(11'd0, 12'd0, MASK_ALL_NEG, MASK_ALL_POS);
      run_phase(120, 255, 1'b1);
      wait_idle();

      // Width above the line length clamps to a full line; the column wraps at its end.
      configure(11'h7FF, 12'd3, random_mask(), random_mask());
      run_phase(LINE_MAX + 40, 255, 1'b0);
      wait_idle();

      // Tallest frame on the narrowest line.
      configure(11'd1, 12'hFFF, random_mask(), MASK_RST);
      run_phase(360, 255, 1'b0);
      wait_idle();

      // Random frame sizes, masks and picture content.
      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         sel = $urandom_range(0, 9);
         if (sel == 0) w = FW_W'($urandom_range(0, 2));
         else if (sel == 9) w = FW_W'($urandom_range(17, 48));
         else w = FW_W'($urandom_range(3, 12));
         if ($urandom_range(0, 9) == 0) h = FH_W'($urandom_range(0, 2));
         else h = FH_W'($urandom_range(3, 8));
         configure(w, h, random_mask(), random_mask());
         case ($urandom_range(0, 2))
            0: span = 255;
            1: span = 31;
            default: span = 7;
         endcase
         n = active_width() * active_height() * $urandom_range(1, 3)
             + $urandom_range(0, 2 * active_width());
         run_phase(n, span, 1'b1);
         random_items += n;
         wait_idle();
      end

      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // Result receiver: its own stall pattern, with long hold-offs to back the block up.
   initial begin
      bit held_once;
      int run;
      held_once = 1'b0;
      rsp_tready <= 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if ((!held_once && results_seen >= HOLD_AFTER) || $urandom_range(0, 255) == 0) begin
            held_once = 1'b1;
            rsp_tready <= 1'b0;
            run = $urandom_range(150, 300);
         end else begin
            case ($urandom_range(0, 3))
               0: begin
                  rsp_tready <= 1'b1;
                  run = $urandom_range(20, 120);
               end
               1: begin
                  rsp_tready <= 1'b0;
                  run = $urandom_range(1, 8);
               end
               default: begin
                  rsp_tready <= 1'($urandom_range(0, 1));
                  run = $urandom_range(1, 4);
               end
            endcase
         end
         repeat (run) @(posedge clock);
      end
   end

   // Result checker: each transfer is compared with the oldest owed result.
   always @(negedge clock) begin
      mag_pixel_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (owed.size() == 0) begin
            report_mismatch("unexpected result", int'(rsp_tdata), 0);
         end else begin
            want = owed.pop_front();
            if (rsp_tdata[ROW_W-1:0] != want.row)
               report_mismatch("row", int'(rsp_tdata[ROW_W-1:0]), int'(want.row));
            if (rsp_tdata[ROW_W +: COL_W] != want.col)
               report_mismatch("column", int'(rsp_tdata[ROW_W +: COL_W]), int'(want.col));
            if (rsp_tdata[ROW_W+COL_W +: PIX_W] != want.value)
               report_mismatch("value", int'(rsp_tdata[ROW_W+COL_W +: PIX_W]),
                               int'(want.value));
            if (rsp_tlast != want.last)
               report_mismatch("last of frame", int'(rsp_tlast), int'(want.last));
         end
      end
   end

   // Watchdog.
   initial begin
      #30_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
